[design/gamepad_report_to_motion_command_core_assert.svh]
// Assertion macros used by the checker file of the gamepad motion core.
`ifndef GAMEPAD_REPORT_TO_MOTION_COMMAND_CORE_ASSERT_SVH
`define GAMEPAD_REPORT_TO_MOTION_COMMAND_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GRMC_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("grmc: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GRMC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("grmc: next-cycle check failed");

`endif

[design/grmc_pkg.sv]
// Package for the gamepad motion core: constants, codes, beat layouts, decode helpers.
package grmc_pkg;

  // Report geometry
  localparam int REPORT_LEN = 16;
  localparam int COUNT_CAP  = REPORT_LEN + 2;
  localparam int CNT_W      = $clog2(COUNT_CAP + 1);
  localparam int LINE_W     = REPORT_LEN * 8;

  // Byte offsets of the fields inside a report body
  localparam int OFS_LX    = 0;
  localparam int OFS_LY    = 2;
  localparam int OFS_RX    = 4;
  localparam int OFS_RY    = 6;
  localparam int OFS_TL    = 8;
  localparam int OFS_TR    = 10;
  localparam int OFS_HAT   = 12;
  localparam int OFS_MAIN  = 13;
  localparam int OFS_CTRL  = 14;
  localparam int OFS_EXTRA = 15;

  // Hat switch codes
  localparam logic [7:0] HAT_N  = 8'd1;
  localparam logic [7:0] HAT_NE = 8'd2;
  localparam logic [7:0] HAT_SE = 8'd4;
  localparam logic [7:0] HAT_SW = 8'd6;
  localparam logic [7:0] HAT_NW = 8'd8;

  // Axis arithmetic
  localparam int AXIS_W    = 16;
  localparam int CMD_W     = 17;
  localparam int Q_W       = 17;
  localparam int PROD_W    = Q_W + AXIS_W;
  localparam int DIV_STEPS = 16;
  localparam int DIV_CW    = $clog2(DIV_STEPS + 1);
  localparam logic [Q_W-1:0]    AXIS_MAX  = 17'h0FFFF;
  localparam logic [Q_W-1:0]    AXIS_FULL = 17'h10000;
  localparam logic [PROD_W:0]   ROUND_HALF = 34'h0_0000_8000;
  localparam logic [AXIS_W-1:0] DZ_MAX    = 16'd39322;

  // Register reset values
  localparam logic [15:0] DEAD_ZONE_RST = 16'd5243;
  localparam logic [15:0] GAIN_FWD_RST  = 16'd614;
  localparam logic [15:0] GAIN_LAT_RST  = 16'd410;
  localparam logic [15:0] GAIN_TURN_RST = 16'd3686;
  localparam logic [15:0] STICK_RST     = 16'd32767;

  // Register indexes
  localparam logic [1:0] REG_DEAD_ZONE = 2'd0;
  localparam logic [1:0] REG_GAIN_FWD  = 2'd1;
  localparam logic [1:0] REG_GAIN_LAT  = 2'd2;
  localparam logic [1:0] REG_GAIN_TURN = 2'd3;

  // Operation codes (tuser of the input beat)
  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_LINK = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // Result kind (tuser of the output beat) and status
  localparam logic KIND_STATUS    = 1'b0;
  localparam logic KIND_MOTION    = 1'b1;
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_LEN = 1'b1;

  // Axis selection
  localparam logic [1:0] AXIS_FWD  = 2'd0;
  localparam logic [1:0] AXIS_LAT  = 2'd1;
  localparam logic [1:0] AXIS_TURN = 2'd2;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 120;

  typedef enum logic [1:0] {
    S_IDLE,
    S_AXIS_GO,
    S_AXIS_WAIT,
    S_EMIT
  } top_state_e;

  typedef enum logic [1:0] {
    A_IDLE,
    A_DIV,
    A_ROUND
  } axis_state_e;

  typedef struct packed {
    logic              start;
    logic              negate;
    logic [AXIS_W-1:0] raw;
    logic [AXIS_W-1:0] gain;
    logic [AXIS_W-1:0] dz;
  } axis_req_t;

  typedef struct packed {
    logic             done;
    logic [CMD_W-1:0] cmd;
  } axis_rsp_t;

  typedef struct packed {
    logic           start;
    logic [Q_W-1:0] num;
    logic [Q_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic [6:0] pad;
    logic       link_up;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]              pad;
    logic [15:0]             report_count;
    logic [15:0]             trigger_right;
    logic [15:0]             trigger_left;
    logic [3:0]              dpad_bits;
    logic [11:0]             button_bits;
    logic                    link_connected;
    logic signed [CMD_W-1:0] turn_rate;
    logic signed [CMD_W-1:0] lateral_velocity;
    logic signed [CMD_W-1:0] forward_velocity;
    logic                    status;
  } out_beat_t;

  // Hat code to up/right/down/left flags
  function automatic logic [3:0] hat_decode(input logic [7:0] h);
    logic [3:0] d;
    d[0] = (h == HAT_N) || (h == HAT_NE) || (h == HAT_NW);
    d[1] = (h >= HAT_NE) && (h <= HAT_SE);
    d[2] = (h >= HAT_SE) && (h <= HAT_SW);
    d[3] = (h >= HAT_SW) && (h <= HAT_NW);
    return d;
  endfunction

  // A, B, X, Y, LB, RB from the main button byte
  function automatic logic [5:0] main_buttons(input logic [7:0] m);
    return {m[7], m[6], m[4], m[3], m[1], m[0]};
  endfunction

  // Select, Start, Guide, LS, RS from the control byte
  function automatic logic [4:0] ctrl_buttons(input logic [7:0] c);
    return c[6:2];
  endfunction

endpackage

[design/grmc_div.sv]
// Radix-2 restoring divider: quo = floor(num * 2^16 / den) for num <= den.
module grmc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  grmc_pkg::div_req_t req_i,
  output grmc_pkg::div_rsp_t rsp_o
);

  logic [grmc_pkg::DIV_CW-1:0] cnt_q;
  logic                        done_q;
  logic [grmc_pkg::Q_W-1:0]    rem_q, den_q, quo_q;
  logic [grmc_pkg::Q_W:0]      rem2, rem2_sub;
  logic                        step_ge, first_ge;

  assign rem2     = {rem_q, 1'b0};
  assign rem2_sub = rem2 - {1'b0, den_q};
  assign step_ge  = rem2 >= {1'b0, den_q};
  assign first_ge = req_i.num >= req_i.den;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      cnt_q  <= grmc_pkg::DIV_CW'(grmc_pkg::DIV_STEPS);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == grmc_pkg::DIV_CW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // integer bit first, then one fraction bit per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      den_q <= req_i.den;
      rem_q <= first_ge ? req_i.num - req_i.den : req_i.num;
      quo_q <= {{(grmc_pkg::Q_W-1){1'b0}}, first_ge};
    end else if (cnt_q != '0) begin
      rem_q <= step_ge ? rem2_sub[grmc_pkg::Q_W-1:0] : rem2[grmc_pkg::Q_W-1:0];
      quo_q <= {quo_q[grmc_pkg::Q_W-2:0], step_ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

[design/grmc_axis.sv]
// Axis unit: normalize, rescaled deadzone through the shared divider, gain and rounding.
module grmc_axis (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  grmc_pkg::axis_req_t req_i,
  output grmc_pkg::axis_rsp_t rsp_o
);

  grmc_pkg::axis_state_e state_q, state_d;
  grmc_pkg::div_req_t    div_req;
  grmc_pkg::div_rsp_t    div_rsp;

  logic [grmc_pkg::Q_W-1:0]    twice, mag_a, norm, dz_ext;
  logic                        pos, dead;
  logic                        neg_q, done_q;
  logic [grmc_pkg::AXIS_W-1:0] gain_q;
  logic [grmc_pkg::PROD_W-1:0] prod_q;
  logic [grmc_pkg::PROD_W:0]   rnd;
  logic [grmc_pkg::CMD_W-1:0]  mag, cmd_q;

  // |2v - 65535| scaled to Q1.16; only full travel maps past 65535
  assign twice  = {req_i.raw, 1'b0};
  assign pos    = req_i.raw[grmc_pkg::AXIS_W-1];
  assign mag_a  = pos ? twice - grmc_pkg::AXIS_MAX : grmc_pkg::AXIS_MAX - twice;
  assign norm   = (mag_a == grmc_pkg::AXIS_MAX) ? grmc_pkg::AXIS_FULL : mag_a;
  assign dz_ext = {1'b0, req_i.dz};
  assign dead   = norm <= dz_ext;

  assign rnd = {1'b0, prod_q} + grmc_pkg::ROUND_HALF;
  assign mag = rnd[grmc_pkg::CMD_W+15:16];

  grmc_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      grmc_pkg::A_IDLE: begin
        if (req_i.start && !dead) state_d = grmc_pkg::A_DIV;
      end
      grmc_pkg::A_DIV: begin
        if (div_rsp.done) state_d = grmc_pkg::A_ROUND;
      end
      grmc_pkg::A_ROUND: begin
        state_d = grmc_pkg::A_IDLE;
      end
      default: state_d = grmc_pkg::A_IDLE;
    endcase
  end

  always_comb begin
    div_req.start = (state_q == grmc_pkg::A_IDLE) && req_i.start && !dead;
    div_req.num   = norm - dz_ext;
    div_req.den   = grmc_pkg::AXIS_FULL - dz_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= grmc_pkg::A_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= ((state_q == grmc_pkg::A_IDLE) && req_i.start && dead) ||
                 (state_q == grmc_pkg::A_ROUND);
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == grmc_pkg::A_IDLE) && req_i.start) begin
      neg_q  <= (pos == req_i.negate);
      gain_q <= req_i.gain;
      cmd_q  <= '0;
    end
    if ((state_q == grmc_pkg::A_DIV) && div_rsp.done) begin
      prod_q <= {{grmc_pkg::AXIS_W{1'b0}}, div_rsp.quo} *
                {{grmc_pkg::Q_W{1'b0}}, gain_q};
    end
    if (state_q == grmc_pkg::A_ROUND) begin
      cmd_q <= neg_q ? (~mag + 1'b1) : mag;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.cmd  = cmd_q;

endmodule

[design/gamepad_report_to_motion_command_core.sv]
// Top level of the gamepad report to motion command core.
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+---------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready    | tuser op, tdata byte+link, tlast
//  m_axis   | out | m_axis_tvalid/tready    | tuser kind, tdata status/cmds/state
//  cfg      | in  | cfg_valid_i/cfg_ready_o | cfg_addr_i index, cfg_data_i value
//
// A final report byte is parsed at its accepting edge; the sequencer then enters the emit
// state, and its status beat is offered once the output register is free. A connected tick
// runs the three axes in turn through one axis unit, each by integer bit at load, 16 divider
// steps, product, rounding and handoff; an axis inside the deadzone skips the divider, and
// the motion beat is offered after the third axis. Reset (rst_ni low, async) centers sticks,
// clears link, counters, buttons, loads register defaults; the byte line is not cleared.
module gamepad_report_to_motion_command_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [grmc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] data_byte, [8] link_up
  input  logic [1:0]                       s_axis_tuser,  // [1:0] operation
  input  logic                             s_axis_tlast,
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] status, [17:1] forward_velocity, [34:18] lateral_velocity,
  // [51:35] turn_rate, [52] link_connected, [64:53] button_bits,
  // [68:65] dpad_bits, [84:69] trigger_left, [100:85] trigger_right,
  // [116:101] report_count, [119:117] zero
  output logic [grmc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                             m_axis_tuser,  // [0] result_kind
  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [1:0]                       cfg_addr_i,
  input  logic [15:0]                      cfg_data_i
);

  grmc_pkg::top_state_e state_q, state_d;
  grmc_pkg::in_beat_t   in_beat;
  grmc_pkg::out_beat_t  out_q, out_d;
  grmc_pkg::axis_req_t  axis_req;
  grmc_pkg::axis_rsp_t  axis_rsp;

  // Configuration registers
  logic [15:0] dead_zone_q, gain_fwd_q, gain_lat_q, gain_turn_q;
  logic [15:0] dz_use;

  // Report assembly: last REPORT_LEN bytes, oldest at the bottom
  logic [grmc_pkg::LINE_W-1:0] line_q, line_d;
  logic [grmc_pkg::CNT_W-1:0]  byte_count_q, len_new;
  logic                        rep_ok;

  // Held controller state
  logic        link_q;
  logic [15:0] lx_q, ly_q, rx_q, ry_q, trig_l_q, trig_r_q, reports_q;
  logic [11:0] buttons_q;
  logic [3:0]  dpad_q;

  // Pending result
  logic                               res_kind_q, res_status_q;
  logic [1:0]                         sel_q;
  logic [grmc_pkg::CMD_W-1:0]         fwd_q, lat_q, turn_q;
  logic                               m_valid_q, m_user_q;

  logic in_acc, load_out;
  logic [1:0] op;

  assign in_beat = grmc_pkg::in_beat_t'(s_axis_tdata);
  assign op      = s_axis_tuser;
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  assign cfg_ready_o = 1'b1;
  assign dz_use      = (dead_zone_q > grmc_pkg::DZ_MAX) ? grmc_pkg::DZ_MAX : dead_zone_q;

  // Length bookkeeping: count saturates past an overlong report
  assign len_new = (byte_count_q < grmc_pkg::CNT_W'(grmc_pkg::COUNT_CAP)) ?
                   byte_count_q + 1'b1 : byte_count_q;
  assign rep_ok  = (len_new == grmc_pkg::CNT_W'(grmc_pkg::REPORT_LEN)) ||
                   (len_new == grmc_pkg::CNT_W'(grmc_pkg::REPORT_LEN + 1));
  // with a leading report ID, it has already dropped out of the bottom
  assign line_d  = {in_beat.data_byte, line_q[grmc_pkg::LINE_W-1:8]};

  grmc_axis u_axis (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (axis_req),
    .rsp_o (axis_rsp)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      grmc_pkg::S_IDLE: begin
        if (in_acc) begin
          case (op)
            grmc_pkg::OP_BYTE: if (s_axis_tlast) state_d = grmc_pkg::S_EMIT;
            grmc_pkg::OP_LINK: if (!in_beat.link_up) state_d = grmc_pkg::S_EMIT;
            grmc_pkg::OP_TICK: state_d = link_q ? grmc_pkg::S_AXIS_GO : grmc_pkg::S_EMIT;
            default:           state_d = grmc_pkg::S_IDLE;
          endcase
        end
      end
      grmc_pkg::S_AXIS_GO: begin
        state_d = grmc_pkg::S_AXIS_WAIT;
      end
      grmc_pkg::S_AXIS_WAIT: begin
        if (axis_rsp.done) begin
          state_d = (sel_q == grmc_pkg::AXIS_TURN) ? grmc_pkg::S_EMIT : grmc_pkg::S_AXIS_GO;
        end
      end
      grmc_pkg::S_EMIT: begin
        if (load_out) state_d = grmc_pkg::S_IDLE;
      end
      default: state_d = grmc_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready  = (state_q == grmc_pkg::S_IDLE);
    load_out       = (state_q == grmc_pkg::S_EMIT) && (!m_valid_q || m_axis_tready);
    axis_req.start = (state_q == grmc_pkg::S_AXIS_GO);
    axis_req.dz    = dz_use;
    case (sel_q)
      grmc_pkg::AXIS_FWD: begin
        axis_req.raw    = ly_q;
        axis_req.gain   = gain_fwd_q;
        axis_req.negate = 1'b1;
      end
      grmc_pkg::AXIS_LAT: begin
        axis_req.raw    = lx_q;
        axis_req.gain   = gain_lat_q;
        axis_req.negate = 1'b0;
      end
      default: begin
        axis_req.raw    = rx_q;
        axis_req.gain   = gain_turn_q;
        axis_req.negate = 1'b0;
      end
    endcase
  end

  // Result beat contents
  always_comb begin
    out_d                  = '0;
    out_d.status           = res_status_q;
    out_d.forward_velocity = fwd_q;
    out_d.lateral_velocity = lat_q;
    out_d.turn_rate        = turn_q;
    out_d.link_connected   = link_q;
    out_d.button_bits      = buttons_q;
    out_d.dpad_bits        = dpad_q;
    out_d.trigger_left     = trig_l_q;
    out_d.trigger_right    = trig_r_q;
    out_d.report_count     = reports_q;
  end

  // Control and held state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= grmc_pkg::S_IDLE;
      dead_zone_q  <= grmc_pkg::DEAD_ZONE_RST;
      gain_fwd_q   <= grmc_pkg::GAIN_FWD_RST;
      gain_lat_q   <= grmc_pkg::GAIN_LAT_RST;
      gain_turn_q  <= grmc_pkg::GAIN_TURN_RST;
      byte_count_q <= '0;
      link_q       <= 1'b0;
      lx_q         <= grmc_pkg::STICK_RST;
      ly_q         <= grmc_pkg::STICK_RST;
      rx_q         <= grmc_pkg::STICK_RST;
      ry_q         <= grmc_pkg::STICK_RST;
      trig_l_q     <= '0;
      trig_r_q     <= '0;
      buttons_q    <= '0;
      dpad_q       <= '0;
      reports_q    <= '0;
      res_kind_q   <= grmc_pkg::KIND_STATUS;
      res_status_q <= grmc_pkg::STATUS_OK;
      sel_q        <= grmc_pkg::AXIS_FWD;
      m_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_addr_i)
          grmc_pkg::REG_DEAD_ZONE: dead_zone_q <= cfg_data_i;
          grmc_pkg::REG_GAIN_FWD:  gain_fwd_q  <= cfg_data_i;
          grmc_pkg::REG_GAIN_LAT:  gain_lat_q  <= cfg_data_i;
          grmc_pkg::REG_GAIN_TURN: gain_turn_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (in_acc) begin
        res_status_q <= grmc_pkg::STATUS_OK;
        sel_q        <= grmc_pkg::AXIS_FWD;
        case (op)
          grmc_pkg::OP_BYTE: begin
            res_kind_q <= grmc_pkg::KIND_STATUS;
            if (!s_axis_tlast) begin
              byte_count_q <= len_new;
            end else begin
              byte_count_q <= '0;
              if (!rep_ok) begin
                res_status_q <= grmc_pkg::STATUS_BAD_LEN;
              end else begin
                // whole report body decoded at once from fixed taps
                lx_q      <= line_d[grmc_pkg::OFS_LX*8 +: 16];
                ly_q      <= line_d[grmc_pkg::OFS_LY*8 +: 16];
                rx_q      <= line_d[grmc_pkg::OFS_RX*8 +: 16];
                ry_q      <= line_d[grmc_pkg::OFS_RY*8 +: 16];
                trig_l_q  <= line_d[grmc_pkg::OFS_TL*8 +: 16];
                trig_r_q  <= line_d[grmc_pkg::OFS_TR*8 +: 16];
                dpad_q    <= grmc_pkg::hat_decode(line_d[grmc_pkg::OFS_HAT*8 +: 8]);
                buttons_q <= {line_d[grmc_pkg::OFS_EXTRA*8],
                              grmc_pkg::ctrl_buttons(line_d[grmc_pkg::OFS_CTRL*8 +: 8]),
                              grmc_pkg::main_buttons(line_d[grmc_pkg::OFS_MAIN*8 +: 8])};
                reports_q <= reports_q + 16'd1;
                link_q    <= 1'b1;
              end
            end
          end
          grmc_pkg::OP_LINK: begin
            res_kind_q <= grmc_pkg::KIND_MOTION;
            link_q     <= in_beat.link_up;
          end
          grmc_pkg::OP_TICK: begin
            res_kind_q <= grmc_pkg::KIND_MOTION;
          end
          default: ;
        endcase
      end

      if ((state_q == grmc_pkg::S_AXIS_WAIT) && axis_rsp.done) begin
        sel_q <= sel_q + 2'd1;
      end

      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload: byte line, axis results, output beat
  always_ff @(posedge clk_i) begin
    if (in_acc && (op == grmc_pkg::OP_BYTE)) begin
      line_q <= line_d;
    end
    if (in_acc) begin
      fwd_q  <= '0;
      lat_q  <= '0;
      turn_q <= '0;
    end else if ((state_q == grmc_pkg::S_AXIS_WAIT) && axis_rsp.done) begin
      case (sel_q)
        grmc_pkg::AXIS_FWD: fwd_q  <= axis_rsp.cmd;
        grmc_pkg::AXIS_LAT: lat_q  <= axis_rsp.cmd;
        default:            turn_q <= axis_rsp.cmd;
      endcase
    end
    if (load_out) begin
      out_q    <= out_d;
      m_user_q <= res_kind_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = m_user_q;

endmodule

[design/grmc_checker.sv]
// Port-level checker for the gamepad motion core, bound to the top level.
`include "gamepad_report_to_motion_command_core_assert.svh"

module grmc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [1:0]                       s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [grmc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tuser
);

  grmc_pkg::out_beat_t beat;
  logic                vel_zero;

  assign beat     = grmc_pkg::out_beat_t'(m_axis_tdata);
  assign vel_zero = (beat.forward_velocity == '0) && (beat.lateral_velocity == '0) &&
                    (beat.turn_rate == '0);

  // a stalled result beat holds
  `GRMC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // a tick always occupies the sequencer, which holds s_axis_tready low after it
  `GRMC_ASSERT_NEXT(a_tick_busy, s_axis_tvalid && s_axis_tready && (s_axis_tuser == grmc_pkg::OP_TICK), !s_axis_tready)

  // parse status beats carry no motion
  `GRMC_ASSERT_SAME(a_status_still, m_axis_tvalid && (m_axis_tuser == grmc_pkg::KIND_STATUS), vel_zero)

  // disconnected means zero command
  `GRMC_ASSERT_SAME(a_down_still, m_axis_tvalid && !beat.link_connected, vel_zero)

  // motion beats never report a length error
  `GRMC_ASSERT_SAME(a_motion_ok, m_axis_tvalid && (m_axis_tuser == grmc_pkg::KIND_MOTION), beat.status == grmc_pkg::STATUS_OK)

endmodule

bind gamepad_report_to_motion_command_core grmc_checker u_grmc_checker (.*);
